### design/raqe_pkg.sv
package raqe_pkg;

    localparam int STORE_DEPTH   = 1024;
    localparam int ELEMENT_WIDTH = 32;

    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int LEN_W    = $clog2(STORE_DEPTH + 1);
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int RESULT_W = 42;
    // exact sum of up to STORE_DEPTH elements
    localparam int ACC_W    = ELEMENT_WIDTH + LEN_W;
    localparam int CMP_W    = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUM    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_AVG    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MIN    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MAX    = 3'd5;

    typedef struct packed {
        logic              go;
        logic [ACC_W-1:0]  mag;
        logic [LEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ACC_W-1:0]  quo;
    } t_div_rsp;

endpackage

### design/raqe_if.sv
interface raqe_in_if import raqe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic signed [VALUE_W-1:0] value;
    logic [START_W-1:0]  start_req;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, kind, value, start_req, count, input ready);
    modport sink   (input valid, kind, value, start_req, count, output ready);
endinterface

interface raqe_out_if import raqe_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result;
    logic                       status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

### design/raqe_div.sv
module raqe_div import raqe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(ACC_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [LEN_W:0]    r_rem;
    logic [ACC_W-1:0]  r_quo;
    logic [LEN_W-1:0]  r_div;

    logic [LEN_W:0]    w_shift;
    logic              w_ge;

    // restoring divide, one quotient bit per cycle
    assign w_shift = {r_rem[LEN_W-1:0], r_quo[ACC_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.go && (r_step == STEP_W'(ACC_W - 1));
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.mag;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
                r_quo  <= {r_quo[ACC_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### design/range_aggregate_query_engine_core.sv
// append and clear beats give no result
// a query over n elements reads one element a cycle while it walks the range
// an average then also runs through the bit-serial divider
// an empty range goes straight to the output with a zero result; queries are handled one at a time
// reset empties the store (length zero); element memory is not cleared
module range_aggregate_query_engine_core import raqe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    raqe_in_if.sink     i_in,
    raqe_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_FIN, S_DIV, S_OUT
    } t_state;

    t_state                     r_state;
    logic [LEN_W-1:0]           r_len;
    logic [ADDR_W-1:0]          r_addr;
    logic [LEN_W-1:0]           r_left;
    logic [LEN_W-1:0]           r_n;
    logic [KIND_W-1:0]          r_kind;
    logic                       r_first;
    logic                       r_rd_valid;
    logic [ELEMENT_WIDTH-1:0]   r_rd_data;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_neg;
    logic                       r_div_go;
    logic signed [RESULT_W-1:0] r_res;
    logic                       r_status;
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out_result;
    logic                       r_out_status;

    logic [ELEMENT_WIDTH-1:0]   element_store [STORE_DEPTH];

    logic                       w_in_fire;
    logic                       w_is_query;
    logic                       w_we;
    logic [CMP_W-1:0]           w_start_wide;
    logic [CMP_W-1:0]           w_len_wide;
    logic [CMP_W-1:0]           w_cnt_wide;
    logic [CMP_W-1:0]           w_avail;
    logic [CMP_W-1:0]           w_n;
    logic                       w_empty;
    logic signed [ACC_W-1:0]    w_elem;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    w_quo_signed;
    logic                       w_out_free;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_is_query = (i_in.kind == KIND_SUM) || (i_in.kind == KIND_AVG) ||
                        (i_in.kind == KIND_MIN) || (i_in.kind == KIND_MAX);
    assign w_we = w_in_fire && (i_in.kind == KIND_APPEND) && (r_len < LEN_W'(STORE_DEPTH));

    // range bounds
    assign w_start_wide = CMP_W'(i_in.start_req);
    assign w_len_wide   = CMP_W'(r_len);
    assign w_cnt_wide   = CMP_W'(i_in.count);
    assign w_empty      = (w_start_wide >= w_len_wide);
    assign w_avail      = w_len_wide - w_start_wide;
    assign w_n = ((w_cnt_wide != '0) && (w_cnt_wide < w_avail)) ? w_cnt_wide : w_avail;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            element_store[ADDR_W'(r_len)] <= i_in.value[ELEMENT_WIDTH-1:0];
        end
        r_rd_data <= element_store[r_addr];
    end

    assign w_elem = ACC_W'(signed'(r_rd_data));

    always_comb begin
        case (r_kind) inside
            KIND_SUM, KIND_AVG: n_acc = r_acc + w_elem;
            KIND_MIN:           n_acc = (r_first || (w_elem < r_acc)) ? w_elem : r_acc;
            KIND_MAX:           n_acc = (r_first || (w_elem > r_acc)) ? w_elem : r_acc;
            default:            n_acc = r_acc;
        endcase
    end

    assign w_div_req.go      = r_div_go;
    assign w_div_req.mag     = r_acc[ACC_W-1] ? (-r_acc) : r_acc;
    assign w_div_req.divisor = r_n;

    raqe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_quo_signed = r_neg ? (-signed'(w_div_rsp.quo)) : signed'(w_div_rsp.quo);
    assign w_out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_rd_valid  <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go   <= (r_state == S_FIN) && (r_kind == KIND_AVG);
            r_rd_valid <= (r_state == S_WALK);
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_rd_valid) begin
                r_acc   <= n_acc;
                r_first <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_kind <= i_in.kind;
                        if (w_we) begin
                            r_len <= r_len + 1'b1;
                        end
                        if (i_in.kind == KIND_CLEAR) begin
                            r_len <= '0;
                        end
                        if (w_is_query) begin
                            if (w_empty) begin
                                r_res    <= '0;
                                r_status <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_addr   <= ADDR_W'(w_start_wide);
                                r_left   <= LEN_W'(w_n);
                                r_n      <= LEN_W'(w_n);
                                r_first  <= 1'b1;
                                r_acc    <= '0;
                                r_status <= 1'b0;
                                r_state  <= S_WALK;
                            end
                        end
                    end
                end
                S_WALK: begin
                    r_addr <= r_addr + 1'b1;
                    r_left <= r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last element is folded in this cycle
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_neg <= r_acc[ACC_W-1];
                    if (r_kind == KIND_AVG) begin
                        r_state  <= S_DIV;
                    end else begin
                        r_res   <= RESULT_W'(r_acc);
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_res   <= RESULT_W'(w_quo_signed);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_result <= r_res;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;
    assign o_out.status = r_out_status;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.result == '0))
        else $error("empty range beat with nonzero result");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(STORE_DEPTH))
        else $error("stored length beyond depth");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0))
        else $error("walk with no elements left");

endmodule
